// ===== rtl/core/clist_pkg.sv =====
package clist_pkg;

	// Default list capacity.
	localparam int unsigned CAPACITY_DEF = 16;

	// Fixed field widths.
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned SUM_W   = 36;

	// Operation codes carried on the mode input.
	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

// ===== rtl/core/compacting_value_list.sv =====
// Bounded list of signed 32-bit values with a running total.
// Input: an item is transferred on a rising edge where start is high and
// busy is low; mode selects append (0) or removal of the first equal
// entry (1), value carries the operand.
// Output: every item yields one result, shown on ok, count and total for
// exactly one cycle while done is high. The receiver cannot stall.
// Timing: an append, or a removal from an empty list, shows its result
// in the cycle after the transfer. A removal scans the stored entries
// one per cycle through the single read port of the entry memory and,
// after a match, writes each later entry one place down as it is read;
// its result is registered once the last held entry has been examined.
// busy is high during the scan, and a new item may be transferred in
// the cycle in which done is shown.
// Reset: count and total clear to zero and the list is empty; the entry
// memory is not cleared and needs no clearing pass.
module compacting_value_list
	import clist_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      mode,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      done,
	output logic                      ok,
	output logic [COUNT_W-1:0]        count,
	output logic signed [SUM_W-1:0]   total
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned FW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [FW-1:0]             fill_q, fill_d;
	logic signed [SUM_W-1:0]   sum_q, sum_d;
	logic [FW-1:0]             idx_q, idx_d;
	logic                      hit_q, hit_d;
	logic signed [VALUE_W-1:0] key_q, key_d;

	logic done_d, ok_d;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic signed [VALUE_W-1:0] mem_rdata;

	logic                      accept;
	logic                      last;
	logic                      match;
	logic [FW-1:0]             idx_inc;
	logic [FW-1:0]             idx_dec;
	logic signed [SUM_W-1:0]   key_wide;
	logic signed [SUM_W-1:0]   value_wide;

	clist_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Helper values for the scan.
	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign idx_inc    = idx_q + FW'(1);
	assign idx_dec    = idx_q - FW'(1);
	assign last       = (idx_q == (fill_q - FW'(1)));
	assign match      = (mem_rdata == key_q);
	assign key_wide   = SUM_W'(key_q);
	assign value_wide = SUM_W'(value);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_REMOVE) && (fill_q != '0)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory control, list bookkeeping and result.
	always_comb begin
		fill_d    = fill_q;
		sum_d     = sum_q;
		idx_d     = idx_q;
		hit_d     = hit_q;
		key_d     = key_q;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = value;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_APPEND) begin
						// Append behind the last entry unless full.
						done_d = 1'b1;
						if (fill_q < FW'(CAPACITY)) begin
							mem_we = 1'b1;
							fill_d = fill_q + FW'(1);
							sum_d  = sum_q + value_wide;
							ok_d   = 1'b1;
						end
					end else if (fill_q == '0) begin
						// Nothing to remove from an empty list.
						done_d = 1'b1;
					end else begin
						// Start the scan at the first entry.
						mem_raddr = '0;
						idx_d     = '0;
						hit_d     = 1'b0;
						key_d     = value;
					end
				end
			end
			ST_SEARCH: begin
				// Fetch the next entry while the current one is examined.
				mem_raddr = idx_inc[AW-1:0];
				// Once matched, move each later entry one place down.
				mem_we    = hit_q;
				mem_waddr = idx_dec[AW-1:0];
				mem_wdata = mem_rdata;
				idx_d     = idx_inc;
				hit_d     = hit_q || match;
				if (last) begin
					done_d = 1'b1;
					if (hit_q || match) begin
						ok_d   = 1'b1;
						fill_d = fill_q - FW'(1);
						sum_d  = sum_q - key_wide;
					end
				end
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			sum_q   <= '0;
			hit_q   <= 1'b0;
			done    <= 1'b0;
			ok      <= 1'b0;
			count   <= '0;
			total   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
			hit_q   <= hit_d;
			done    <= done_d;
			ok      <= ok_d;
			count   <= COUNT_W'(fill_d);
			total   <= sum_d;
		end
	end

	// Scan payload registers.
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		key_q <= key_d;
	end

endmodule

// ===== rtl/core/clist_mem.sv =====
module clist_mem
	import clist_pkg::*;
#(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned AW    = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [VALUE_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic signed [VALUE_W-1:0] rdata
);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/tb_compacting_value_list.sv =====
module tb_compacting_value_list;
	timeunit 1ns;
	timeprecision 1ps;

	import clist_pkg::*;

	localparam int unsigned DEPTH      = CAPACITY_DEF;
	localparam int unsigned PHASE_LEN  = 617;
	localparam int unsigned SHOW_LIMIT = 10;

	// One result as the block reports it.
	typedef struct packed {
		logic                    ok;
		logic [COUNT_W-1:0]      count;
		logic signed [SUM_W-1:0] total;
	} outcome_t;

	// One row of the directed plan; the outcome is used only where typed is set.
	typedef struct packed {
		logic                      mode;
		logic signed [VALUE_W-1:0] value;
		logic                      typed;
		outcome_t                  want;
	} plan_row_t;

	localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh80000000;
	localparam int unsigned PLAN_LEN = 25;

	// Empty list, both value extremes, a full list of minima and its sum floor.
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{MODE_REMOVE, 32'sh0, 1'b1, '{1'b0, 5'd0,  36'h000000000}},
		'{MODE_APPEND, V_MAX,  1'b1, '{1'b1, 5'd1,  36'h07FFFFFFF}},
		'{MODE_APPEND, V_MIN,  1'b1, '{1'b1, 5'd2,  36'hFFFFFFFFF}},
		'{MODE_REMOVE, 32'sh0, 1'b1, '{1'b0, 5'd2,  36'hFFFFFFFFF}},
		'{MODE_REMOVE, V_MIN,  1'b1, '{1'b1, 5'd1,  36'h07FFFFFFF}},
		'{MODE_REMOVE, V_MAX,  1'b1, '{1'b1, 5'd0,  36'h000000000}},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b0, '0},
		'{MODE_APPEND, V_MIN,  1'b1, '{1'b1, 5'd16, 36'h800000000}},
		'{MODE_APPEND, V_MAX,  1'b1, '{1'b0, 5'd16, 36'h800000000}},
		'{MODE_REMOVE, V_MAX,  1'b1, '{1'b0, 5'd16, 36'h800000000}},
		'{MODE_REMOVE, V_MIN,  1'b1, '{1'b1, 5'd15, 36'h880000000}}
	};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      mode;
	logic signed [VALUE_W-1:0] value;
	logic                      done;
	logic                      ok;
	logic [COUNT_W-1:0]        count;
	logic signed [SUM_W-1:0]   total;

	// Shadow copy of the list kept by the predictor.
	logic signed [VALUE_W-1:0] held [DEPTH];
	int unsigned               held_n;
	logic signed [SUM_W-1:0]   held_sum;

	outcome_t    results_due [$];
	outcome_t    cur_want;
	logic        cur_typed;
	int unsigned transfers;
	int unsigned results_seen;
	int unsigned failures;
	int unsigned idle_pct;
	int unsigned n_append_ok, n_full, n_remove_ok, n_miss, n_empty_hits, n_full_hits;

	compacting_value_list u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.mode   (mode),
		.value  (value),
		.done   (done),
		.ok     (ok),
		.count  (count),
		.total  (total)
	);

	always #5 clk = ~clk;

	// Apply one item to the shadow list and return the result it should give.
	function automatic outcome_t list_apply(logic m, logic signed [VALUE_W-1:0] v);
		outcome_t                r;
		logic signed [SUM_W-1:0] wide;
		int                      pos;
		bit                      hit;
		wide = {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
		r.ok = 1'b0;
		if (m == MODE_APPEND) begin
			if (held_n < DEPTH) begin
				held[held_n] = v;
				held_n++;
				held_sum = held_sum + wide;
				r.ok = 1'b1;
				n_append_ok++;
			end else begin
				n_full++;
			end
		end else begin
			hit = 1'b0;
			pos = 0;
			for (int k = 0; k < int'(held_n); k++) begin
				if (!hit && held[k] == v) begin
					hit = 1'b1;
					pos = k;
				end
			end
			if (hit) begin
				for (int k = pos + 1; k < int'(held_n); k++)
					held[k-1] = held[k];
				held[held_n-1] = '0;
				held_n--;
				held_sum = held_sum - wide;
				r.ok = 1'b1;
				n_remove_ok++;
			end else begin
				n_miss++;
			end
		end
		if (held_n == 0)
			n_empty_hits++;
		if (held_n == DEPTH)
			n_full_hits++;
		r.count = COUNT_W'(held_n);
		r.total = held_sum;
		return r;
	endfunction

	// Check each result against the oldest one due, then record a new transfer.
	always @(posedge clk) begin : monitor
		outcome_t w;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (results_due.size() == 0) begin
					failures++;
					if (failures <= SHOW_LIMIT)
						$display("%0t: result with none due: ok=%0b count=%0d total=%0d",
							$realtime, ok, count, total);
				end else begin
					w = results_due.pop_front();
					if (ok !== w.ok || count !== w.count || total !== w.total) begin
						failures++;
						if (failures <= SHOW_LIMIT) begin
							$display("%0t: result %0d wrong: expected ok=%0b count=%0d total=%0d",
								$realtime, results_seen, w.ok, w.count, w.total);
							$display("    got ok=%0b count=%0d total=%0d", ok, count, total);
						end
					end
				end
			end
			if (start && !busy) begin
				w = list_apply(mode, value);
				results_due.push_back(cur_typed ? cur_want : w);
				transfers++;
			end
		end
	end

	// Present one item from a falling edge and hold it until its transfer.
	task automatic send_item(logic m, logic signed [VALUE_W-1:0] v, logic typed,
			outcome_t want);
		int unsigned seen;
		seen = transfers;
		cur_typed = typed;
		cur_want = want;
		start <= 1'b1;
		mode <= m;
		value <= v;
		do
			@(negedge clk);
		while (transfers == seen);
		// Sender gaps, mostly short so that they land inside a scan, some long.
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 20 : 4)) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every result due has arrived.
	task automatic drain();
		int unsigned guard;
		guard = 0;
		start <= 1'b0;
		while (results_due.size() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DEPTH + 3) @(negedge clk);
	endtask

	// Random traffic in bursts that grow, shrink or hover around the list's size.
	task automatic random_traffic(int unsigned n);
		int unsigned               burst_left;
		int unsigned               grow_pct;
		bit                        uniform;
		logic signed [VALUE_W-1:0] same_val;
		logic                      m;
		logic signed [VALUE_W-1:0] v;
		burst_left = 0;
		grow_pct = 50;
		uniform = 1'b0;
		same_val = '0;
		repeat (n) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(10, 40);
				uniform = 1'b0;
				case ($urandom_range(3))
					0: grow_pct = 50;
					1: grow_pct = 85;
					2: grow_pct = 15;
					default: begin
						grow_pct = 90;
						uniform = 1'b1;
						same_val = $urandom_range(1) ? V_MAX : V_MIN;
					end
				endcase
			end
			burst_left--;
			m = ($urandom_range(99) < grow_pct) ? MODE_APPEND : MODE_REMOVE;
			if (m == MODE_REMOVE && held_n > 0 && $urandom_range(99) < 65) begin
				v = held[$urandom_range(held_n - 1)];
			end else if (uniform) begin
				v = same_val;
			end else begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8: v = $signed($urandom_range(8)) - 4;
					9:  v = V_MAX;
					10: v = V_MIN;
					default: v = $urandom;
				endcase
			end
			send_item(m, v, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_APPEND;
		value = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		held_n = 0;
		held_sum = '0;
		for (int k = 0; k < int'(DEPTH); k++)
			held[k] = '0;
		transfers = 0;
		results_seen = 0;
		failures = 0;
		idle_pct = 23;
		n_append_ok = 0;
		n_full = 0;
		n_remove_ok = 0;
		n_miss = 0;
		n_empty_hits = 0;
		n_full_hits = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed plan, then a pause until the list has settled.
		for (int i = 0; i < int'(PLAN_LEN); i++)
			send_item(PLAN[i].mode, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
		drain();

		// Three random phases: sender idle 23 %, then 50 %, then never.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 23 : (phase == 1) ? 50 : 0;
			random_traffic(PHASE_LEN);
			drain();
		end

		if (results_due.size() != 0) begin
			failures += results_due.size();
			$display("%0d results never arrived", results_due.size());
		end
		$display("Sent %0d items: %0d appends stored, %0d refused on a full list,",
			transfers, n_append_ok, n_full);
		$display("%0d removals done, %0d found no match; list empty %0d and full %0d times.",
			n_remove_ok, n_miss, n_empty_hits, n_full_hits);
		if (failures == 0)
			$display("compacting_value_list: match");
		else
			$display("compacting_value_list: mismatch");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5ms;
		$display("compacting_value_list: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/clist_pkg.sv
rtl/core/clist_mem.sv
rtl/core/compacting_value_list.sv
bench/tb_compacting_value_list.sv
